// ----- design/tvg_pkg.sv -----
// Shared types, command codes and constants of the turtle vector generator.
package tvg_pkg;

    // Command codes carried in the opcode field.
    typedef enum logic [3:0] {
        OP_FWD     = 4'd0,
        OP_BACK    = 4'd1,
        OP_ROTATE  = 4'd2,
        OP_RIGHT   = 4'd3,
        OP_LEFT    = 4'd4,
        OP_ARC     = 4'd5,
        OP_SETX    = 4'd6,
        OP_SETY    = 4'd7,
        OP_SETPOS  = 4'd8,
        OP_SETHEAD = 4'd9,
        OP_PENON   = 4'd10,
        OP_PENOFF  = 4'd11
    } t_opcode;

    // One command item.
    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [19:0] distance;
        logic signed [15:0] turn_angle;
        logic signed [7:0]  arc_degrees;
        logic [11:0]        arc_radius;
        logic signed [23:0] new_x;
        logic signed [23:0] new_y;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic [12:0]        heading_out;
        logic               draw;
        logic               pen_down;
        logic               last;
    } t_seg;

    // Width of the CORDIC datapath and of the sine and cosine it returns.
    localparam int TRIG_W = 27;

    // Cosine and sine from the CORDIC unit, Q.24.
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
    } t_trig;

    // Heading units: 1/16 degree.
    localparam logic [12:0] FULL_TURN    = 13'd5760;
    localparam logic [12:0] HALF_TURN    = 13'd2880;
    localparam logic [12:0] QUARTER_TURN = 13'd1440;
    localparam logic [12:0] ONE_DEGREE   = 13'd16;

    // CORDIC start value, pre-scaled by the inverse gain, Q.24.
    localparam logic [23:0] CORDIC_GAIN = 24'd10188013;

    // Chord length per unit radius: 2*pi/360 in Q.24, result taken to Q.8.
    localparam logic [18:0] ARC_LEN_COEF = 19'd292818;

    // Saturation limits of a Q16.8 position.
    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;

    // atan(2^-i) in 1/65536 degree.
    function automatic logic [21:0] tvg_atan(input logic [4:0] idx);
        logic [21:0] val;
        case (idx)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- design/tvg_cordic.sv -----
// Iterative CORDIC giving the cosine and sine of a heading, one rotation per cycle.
module tvg_cordic #(
    parameter int ITERS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [12:0]         i_angle,
    output logic                o_done,
    output tvg_pkg::t_trig      o_trig
);
    import tvg_pkg::*;

    localparam int IW = $clog2(ITERS);

    logic signed [TRIG_W-1:0] r_x;
    logic signed [TRIG_W-1:0] r_y;
    logic signed [24:0]       r_z;
    logic [1:0]               r_quad;
    logic [IW-1:0]            r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [1:0]               quad;
    logic [12:0]              rem;
    logic signed [TRIG_W-1:0] x_sh;
    logic signed [TRIG_W-1:0] y_sh;
    logic signed [24:0]       atan_val;

    // Split the heading into a quadrant and an angle within it.
    always_comb begin
        if (i_angle >= 13'(3 * QUARTER_TURN)) begin
            quad = 2'd3;
            rem  = i_angle - 13'(3 * QUARTER_TURN);
        end else if (i_angle >= HALF_TURN) begin
            quad = 2'd2;
            rem  = i_angle - HALF_TURN;
        end else if (i_angle >= QUARTER_TURN) begin
            quad = 2'd1;
            rem  = i_angle - QUARTER_TURN;
        end else begin
            quad = 2'd0;
            rem  = i_angle;
        end
    end

    // Shifted terms and arctangent for the current rotation.
    assign x_sh     = r_x >>> r_cnt;
    assign y_sh     = r_y >>> r_cnt;
    assign atan_val = $signed({3'b000, tvg_atan(5'(r_cnt))});

    // Rotation sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == IW'(ITERS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == IW'(ITERS - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Datapath: load on start, then rotate towards zero residual angle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= $signed({3'b000, CORDIC_GAIN});
            r_y    <= '0;
            r_z    <= $signed({rem[11:0], 12'b0, 1'b0}) >>> 1;
            r_quad <= quad;
        end else if (r_busy) begin
            if (!r_z[24]) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_val;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_val;
            end
        end
    end

    // Map the first-quadrant result back onto the full circle.
    always_comb begin
        case (r_quad)
            2'd0: begin
                o_trig.cos_val = r_x;
                o_trig.sin_val = r_y;
            end
            2'd1: begin
                o_trig.cos_val = -r_y;
                o_trig.sin_val = r_x;
            end
            2'd2: begin
                o_trig.cos_val = -r_x;
                o_trig.sin_val = -r_y;
            end
            default: begin
                o_trig.cos_val = r_y;
                o_trig.sin_val = -r_x;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

// ----- design/turtle_vector_generator.sv -----
// Top level of the turtle vector generator: command sequencer, position and heading state.
//
// Commands arrive on the input channel (i_valid, o_ready, i_cmd) and segments leave on the
// output channel (o_valid, i_ready, o_seg). A transfer happens on a rising edge at which
// valid and ready are both high. The block takes one command at a time; o_ready is high
// only while the sequencer is idle.
// A move (forward or back) runs the iterative CORDIC, one rotation per cycle, then one shared
// multiplier forms the x and y offsets. An arc first works out the chord length and the
// optional half turn, then runs these steps once per chord, giving up to MAX_ARC_STEPS
// segments with last set on the final one. Turns and set-heading commands reduce the
// heading by one full turn per cycle until it lies within one turn; the remaining commands
// go straight to the output.
// Each segment is held in an output register; the sequencer may start the next chord or
// return to idle while it waits, and stalls only when a new segment is ready and the
// register is still full.
// Reset puts the cursor at the origin, heading zero, pen on, with no segment pending.
module turtle_vector_generator #(
    parameter int MAX_ARC_STEPS = 64,
    parameter int CORDIC_ITERS  = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tvg_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output tvg_pkg::t_seg  o_seg
);
    import tvg_pkg::*;

    localparam int CW = $clog2(MAX_ARC_STEPS + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_ARCLEN = 9'b000000010,
        S_WRAP   = 9'b000000100,
        S_START  = 9'b000001000,
        S_TRIG   = 9'b000010000,
        S_MULX   = 9'b000100000,
        S_MULY   = 9'b001000000,
        S_ADDY   = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state             r_state;
    logic signed [23:0] r_pos_x;
    logic signed [23:0] r_pos_y;
    logic [12:0]        r_heading;
    logic               r_pen;
    logic signed [16:0] r_hacc;
    logic signed [20:0] r_dist;
    logic signed [47:0] r_prod;
    logic signed [23:0] r_sx0;
    logic signed [23:0] r_sy0;
    logic [11:0]        r_rad;
    logic               r_neg;
    logic               r_is_arc;
    logic               r_in_chord;
    logic [CW-1:0]      r_cnt;
    logic               r_ovalid;
    t_seg               r_seg;

    logic               cordic_start;
    logic               cordic_done;
    t_trig              trig;
    logic signed [TRIG_W-1:0] mul_b;
    logic signed [23:0] rnd;
    logic [31:0]        arc_prod;
    logic signed [16:0] ang_ext;
    logic signed [16:0] mag;
    logic signed [16:0] head_ext;
    logic [8:0]         span;
    logic               out_load;
    logic               more_chords;
    logic               accept;

    // Add a rounded offset to a position and clamp to the Q16.8 range.
    function automatic logic signed [23:0] sat_add(input logic signed [23:0] pos,
                                                   input logic signed [23:0] off);
        logic signed [25:0] sum;
        sum = 26'(pos) + 26'(off);
        if (sum > 26'(POS_MAX)) begin
            return POS_MAX;
        end else if (sum < 26'(POS_MIN)) begin
            return POS_MIN;
        end
        return sum[23:0];
    endfunction

    tvg_cordic #(
        .ITERS (CORDIC_ITERS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (r_heading),
        .o_done  (cordic_done),
        .o_trig  (trig)
    );

    // Handshake and decode helpers.
    assign accept       = i_valid && (r_state == S_IDLE);
    assign cordic_start = (r_state == S_START);
    assign ang_ext      = 17'(i_cmd.turn_angle);
    assign mag          = i_cmd.turn_angle[15] ? -ang_ext : ang_ext;
    assign head_ext     = $signed({4'b0000, r_heading});
    assign span         = i_cmd.arc_degrees[7] ? -9'(i_cmd.arc_degrees)
                                               : 9'(i_cmd.arc_degrees);
    assign arc_prod     = 32'(r_rad) * 32'(ARC_LEN_COEF) + 32'd32768;

    // The shared multiplier takes the cosine first, then the sine.
    assign mul_b = (r_state == S_MULX) ? trig.cos_val : trig.sin_val;
    assign rnd   = 24'((r_prod + 48'sd8388608) >>> 24);

    assign out_load    = (r_state == S_OUT) && (!r_ovalid || i_ready);
    assign more_chords = r_is_arc && r_in_chord && (r_cnt > CW'(1));

    // Sequencer and cursor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_heading  <= '0;
            r_pen      <= 1'b1;
            r_is_arc   <= 1'b0;
            r_in_chord <= 1'b0;
            r_cnt      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_is_arc   <= (i_cmd.opcode == OP_ARC);
                        r_in_chord <= 1'b0;
                        case (i_cmd.opcode)
                            OP_FWD: begin
                                r_dist  <= 21'(i_cmd.distance);
                                r_state <= S_START;
                            end
                            OP_BACK: begin
                                r_dist  <= -21'(i_cmd.distance);
                                r_state <= S_START;
                            end
                            OP_ROTATE: begin
                                r_hacc  <= head_ext + ang_ext;
                                r_state <= S_WRAP;
                            end
                            OP_RIGHT: begin
                                r_hacc  <= head_ext + mag;
                                r_state <= S_WRAP;
                            end
                            OP_LEFT: begin
                                r_hacc  <= head_ext - mag;
                                r_state <= S_WRAP;
                            end
                            OP_SETHEAD: begin
                                r_hacc  <= ang_ext;
                                r_state <= S_WRAP;
                            end
                            OP_ARC: begin
                                r_rad    <= i_cmd.arc_radius;
                                r_neg    <= i_cmd.arc_degrees[7];
                                if (span > 9'(MAX_ARC_STEPS)) begin
                                    r_cnt <= CW'(MAX_ARC_STEPS);
                                end else begin
                                    r_cnt <= CW'(span);
                                end
                                r_state <= S_ARCLEN;
                            end
                            OP_SETX: begin
                                r_pos_x <= i_cmd.new_x;
                                r_state <= S_OUT;
                            end
                            OP_SETY: begin
                                r_pos_y <= i_cmd.new_y;
                                r_state <= S_OUT;
                            end
                            OP_SETPOS: begin
                                r_pos_x <= i_cmd.new_x;
                                r_pos_y <= i_cmd.new_y;
                                r_state <= S_OUT;
                            end
                            OP_PENON: begin
                                r_pen   <= 1'b1;
                                r_state <= S_OUT;
                            end
                            OP_PENOFF: begin
                                r_pen   <= 1'b0;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                // Chord length, and the half turn that opens a negative arc.
                S_ARCLEN: begin
                    r_dist  <= $signed({5'b00000, arc_prod[31:16]});
                    r_hacc  <= r_neg ? head_ext + 17'(HALF_TURN) : head_ext;
                    r_state <= S_WRAP;
                end
                // Bring the heading back into one turn, one full turn per cycle.
                S_WRAP: begin
                    if (r_hacc[16]) begin
                        r_hacc <= r_hacc + 17'(FULL_TURN);
                    end else if (r_hacc >= 17'(FULL_TURN)) begin
                        r_hacc <= r_hacc - 17'(FULL_TURN);
                    end else begin
                        r_heading <= r_hacc[12:0];
                        if (r_is_arc && !r_in_chord && (r_cnt != '0)) begin
                            r_state <= S_START;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                // Segment begins here; the CORDIC starts this cycle.
                S_START: begin
                    r_sx0      <= r_pos_x;
                    r_sy0      <= r_pos_y;
                    r_in_chord <= 1'b1;
                    r_state    <= S_TRIG;
                end
                S_TRIG: begin
                    if (cordic_done) begin
                        r_state <= S_MULX;
                    end
                end
                S_MULX: begin
                    r_prod  <= r_dist * mul_b;
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_prod  <= r_dist * mul_b;
                    r_pos_x <= sat_add(r_pos_x, rnd);
                    r_state <= S_ADDY;
                end
                S_ADDY: begin
                    r_pos_y <= sat_add(r_pos_y, rnd);
                    if (r_is_arc) begin
                        r_hacc  <= r_neg ? head_ext - 17'(ONE_DEGREE)
                                         : head_ext + 17'(ONE_DEGREE);
                        r_state <= S_WRAP;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                // Hand the segment to the output register, then go on or idle.
                S_OUT: begin
                    if (out_load) begin
                        if (more_chords) begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_state <= S_START;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: holds one segment until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_seg.start_x     <= r_in_chord ? r_sx0 : r_pos_x;
            r_seg.start_y     <= r_in_chord ? r_sy0 : r_pos_y;
            r_seg.end_x       <= r_pos_x;
            r_seg.end_y       <= r_pos_y;
            r_seg.heading_out <= r_heading;
            r_seg.draw        <= r_in_chord & r_pen;
            r_seg.pen_down    <= r_pen;
            r_seg.last        <= !(r_is_arc && r_in_chord) || (r_cnt == CW'(1));
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_seg   = r_seg;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the turtle vector generator: directed commands, then random ones.
module testbench;
    import tvg_pkg::*;

    localparam int CORDIC_ROUNDS = 16;
    localparam int ARC_STEP_CAP  = 64;

    // Opcodes past the last defined command; the block must leave its state alone for these.
    localparam logic [3:0] FIRST_SPARE_OP = 4'd12;
    localparam logic [3:0] LAST_SPARE_OP  = 4'd15;

    // Half of one Q.8 step in a Q.32 product, for rounding the move offsets.
    localparam longint MOVE_ROUND = 64'sd8388608;

    // atan(2^-i) in 1/65536 degree, one entry per CORDIC rotation.
    localparam longint ATAN_STEP [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic i_clk;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    t_cmd cmd_bus   = '0;
    logic seg_ready = 1'b0;
    logic cmd_ready;
    logic seg_valid;
    t_seg seg_bus;

    turtle_vector_generator #(
        .MAX_ARC_STEPS (ARC_STEP_CAP),
        .CORDIC_ITERS  (CORDIC_ROUNDS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_valid (cmd_valid),
        .o_ready (cmd_ready),
        .i_cmd   (cmd_bus),
        .o_valid (seg_valid),
        .i_ready (seg_ready),
        .o_seg   (seg_bus)
    );

    // Cursor state as the block should hold it.
    logic signed [23:0] cursor_x     = '0;
    logic signed [23:0] cursor_y     = '0;
    logic [12:0]        cursor_head  = '0;
    logic               cursor_pen   = 1'b1;

    t_seg pending_segments[$];
    int   mismatch_count = 0;
    logic send_gaps_on   = 1'b1;
    logic stall_gaps_on  = 1'b1;
    int   stall_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [12:0] wrap_heading(input int raw);
        int rem;
        rem = raw % int'(FULL_TURN);
        if (rem < 0) begin
            rem += int'(FULL_TURN);
        end
        return rem[12:0];
    endfunction

    function automatic logic signed [23:0] clamp_pos(input longint val);
        if (val > longint'(POS_MAX)) begin
            return POS_MAX;
        end
        if (val < longint'(POS_MIN)) begin
            return POS_MIN;
        end
        return val[23:0];
    endfunction

    // Cosine and sine of a heading, Q.24: CORDIC over one quadrant, then quadrant folding.
    function automatic void sine_cosine(input int hdg, output longint cos_q, output longint sin_q);
        int     quadrant;
        int     idx;
        longint x, y, z, xs, ys;
        quadrant = hdg / int'(QUARTER_TURN);
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = longint'(hdg % int'(QUARTER_TURN)) * 4096;
        for (idx = 0; idx < CORDIC_ROUNDS && idx < 24; idx++) begin
            xs = x >>> idx;
            ys = y >>> idx;
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= ATAN_STEP[idx];
            end else begin
                x += ys;
                y -= xs;
                z += ATAN_STEP[idx];
            end
        end
        case (quadrant & 3)
            0: begin
                cos_q = x;
                sin_q = y;
            end
            1: begin
                cos_q = -y;
                sin_q = x;
            end
            2: begin
                cos_q = -x;
                sin_q = -y;
            end
            default: begin
                cos_q = y;
                sin_q = -x;
            end
        endcase
    endfunction

    function automatic void advance_cursor(input longint move_len);
        longint cos_q, sin_q;
        sine_cosine(int'(cursor_head), cos_q, sin_q);
        cursor_x = clamp_pos(longint'(cursor_x) + ((move_len * cos_q + MOVE_ROUND) >>> 24));
        cursor_y = clamp_pos(longint'(cursor_y) + ((move_len * sin_q + MOVE_ROUND) >>> 24));
    endfunction

    function automatic void queue_segment(input logic signed [23:0] from_x,
                                          input logic signed [23:0] from_y,
                                          input logic drawn, input logic final_seg);
        t_seg seg;
        seg.start_x     = from_x;
        seg.start_y     = from_y;
        seg.end_x       = cursor_x;
        seg.end_y       = cursor_y;
        seg.heading_out = cursor_head;
        seg.draw        = drawn;
        seg.pen_down    = cursor_pen;
        seg.last        = final_seg;
        pending_segments.push_back(seg);
    endfunction

    // Updates the cursor for one accepted command and queues the segments it must produce.
    function automatic void turtle_predict(input t_cmd cmd);
        longint             move_len, chord;
        int                 ang, mag, arc_deg, span, step;
        logic signed [23:0] from_x, from_y;
        move_len = longint'(cmd.distance);
        ang      = int'(cmd.turn_angle);
        mag      = (ang < 0) ? -ang : ang;
        arc_deg  = int'(cmd.arc_degrees);
        from_x   = cursor_x;
        from_y   = cursor_y;
        case (cmd.opcode)
            OP_FWD, OP_BACK: begin
                advance_cursor((cmd.opcode == OP_BACK) ? -move_len : move_len);
                queue_segment(from_x, from_y, cursor_pen, 1'b1);
                return;
            end
            OP_ARC: begin
                span  = (arc_deg < 0) ? -arc_deg : arc_deg;
                chord = (longint'(cmd.arc_radius) * longint'(ARC_LEN_COEF) + 32768) >>> 16;
                if (span > ARC_STEP_CAP) begin
                    span = ARC_STEP_CAP;
                end
                // A negative arc turns about first and then curls the other way.
                if (arc_deg < 0) begin
                    cursor_head = wrap_heading(int'(cursor_head) + int'(HALF_TURN));
                end
                if (span == 0) begin
                    queue_segment(cursor_x, cursor_y, 1'b0, 1'b1);
                    return;
                end
                for (step = 0; step < span; step++) begin
                    from_x = cursor_x;
                    from_y = cursor_y;
                    advance_cursor(chord);
                    cursor_head = wrap_heading(int'(cursor_head) +
                                               ((arc_deg < 0) ? -int'(ONE_DEGREE)
                                                              : int'(ONE_DEGREE)));
                    queue_segment(from_x, from_y, cursor_pen, step == span - 1);
                end
                return;
            end
            OP_ROTATE:  cursor_head = wrap_heading(int'(cursor_head) + ang);
            OP_RIGHT:   cursor_head = wrap_heading(int'(cursor_head) + mag);
            OP_LEFT:    cursor_head = wrap_heading(int'(cursor_head) - mag);
            OP_SETX:    cursor_x = cmd.new_x;
            OP_SETY:    cursor_y = cmd.new_y;
            OP_SETPOS: begin
                cursor_x = cmd.new_x;
                cursor_y = cmd.new_y;
            end
            OP_SETHEAD: cursor_head = wrap_heading(ang);
            OP_PENON:   cursor_pen = 1'b1;
            OP_PENOFF:  cursor_pen = 1'b0;
            default: ;
        endcase
        queue_segment(cursor_x, cursor_y, 1'b0, 1'b1);
    endfunction

    function automatic string describe_segment(input t_seg seg);
        return $sformatf("start=(%0d,%0d) end=(%0d,%0d) heading=%0d draw=%0b pen=%0b last=%0b",
                         seg.start_x, seg.start_y, seg.end_x, seg.end_y, seg.heading_out,
                         seg.draw, seg.pen_down, seg.last);
    endfunction

    // Segment receiver: checks each transfer against the oldest expectation, then may stall.
    always @(posedge i_clk) begin
        t_seg want;
        if (!rst_n) begin
            seg_ready  <= 1'b1;
            stall_left = 0;
        end else if (seg_valid && seg_ready) begin
            if (pending_segments.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected segment: %s", describe_segment(seg_bus));
                end
            end else begin
                want = pending_segments.pop_front();
                if (seg_bus.start_x !== want.start_x || seg_bus.start_y !== want.start_y ||
                    seg_bus.end_x !== want.end_x || seg_bus.end_y !== want.end_y ||
                    seg_bus.heading_out !== want.heading_out || seg_bus.draw !== want.draw ||
                    seg_bus.pen_down !== want.pen_down || seg_bus.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("segment mismatch at %0t ns", $time);
                        $display("  expected %s", describe_segment(want));
                        $display("  actual   %s", describe_segment(seg_bus));
                    end
                end
            end
            stall_left = stall_gaps_on ? $urandom_range(0, 15) : 0;
            seg_ready  <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            seg_ready <= (stall_left == 0);
        end
    end

    // Presents one command after an optional gap and returns at the edge of its transfer.
    task automatic send_command(input t_cmd cmd);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_bus   <= cmd;
        @(posedge i_clk);
        while (!cmd_ready) @(posedge i_clk);
        turtle_predict(cmd);
    endtask

    function automatic t_cmd bare_command(input logic [3:0] op);
        t_cmd cmd;
        cmd        = '0;
        cmd.opcode = op;
        return cmd;
    endfunction

    // Pen off and on around moves, and the spare opcodes that must change nothing.
    task automatic test_pen_and_spare_codes();
        t_cmd cmd;
        send_command(bare_command(OP_PENOFF));
        cmd          = bare_command(OP_FWD);
        cmd.distance = 20'sd256;
        send_command(cmd);
        send_command(bare_command(OP_PENON));
        send_command(cmd);
        send_command(bare_command(FIRST_SPARE_OP));
        send_command(bare_command(LAST_SPARE_OP));
    endtask

    // Turns by the extreme angles, including the most negative magnitude, and a quadrant edge.
    task automatic test_turns();
        t_cmd cmd;
        cmd            = bare_command(OP_SETHEAD);
        cmd.turn_angle = -16'sd32768;
        send_command(cmd);
        cmd.opcode     = OP_ROTATE;
        cmd.turn_angle = 16'sd32767;
        send_command(cmd);
        cmd.opcode     = OP_RIGHT;
        cmd.turn_angle = -16'sd32768;
        send_command(cmd);
        cmd.opcode     = OP_LEFT;
        send_command(cmd);
        cmd.opcode     = OP_ROTATE;
        send_command(cmd);
        cmd.opcode     = OP_SETHEAD;
        cmd.turn_angle = 16'(QUARTER_TURN);
        send_command(cmd);
        cmd            = bare_command(OP_FWD);
        cmd.distance   = 20'sd256;
        send_command(cmd);
    endtask

    // Longest moves from the corners of the position range, so that both ends saturate.
    task automatic test_moves_and_saturation();
        t_cmd cmd;
        send_command(bare_command(OP_SETHEAD));
        cmd        = bare_command(OP_SETPOS);
        cmd.new_x  = POS_MAX;
        cmd.new_y  = POS_MAX;
        send_command(cmd);
        cmd          = bare_command(OP_FWD);
        cmd.distance = 20'sd524287;
        send_command(cmd);
        cmd        = bare_command(OP_SETX);
        cmd.new_x  = POS_MIN;
        send_command(cmd);
        cmd        = bare_command(OP_SETY);
        cmd.new_y  = POS_MIN;
        send_command(cmd);
        cmd          = bare_command(OP_BACK);
        cmd.distance = 20'sd524287;
        send_command(cmd);
        cmd.opcode   = OP_FWD;
        cmd.distance = -20'sd524288;
        send_command(cmd);
    endtask

    // Zero span, capped spans in both directions, and the smallest and largest radii.
    task automatic test_arcs();
        t_cmd cmd;
        cmd             = bare_command(OP_ARC);
        cmd.arc_radius  = 12'd4095;
        send_command(cmd);
        cmd.arc_degrees = -8'sd128;
        send_command(cmd);
        cmd.arc_degrees = 8'sd127;
        cmd.arc_radius  = 12'd0;
        send_command(cmd);
        cmd.arc_degrees = -8'sd1;
        cmd.arc_radius  = 12'd1;
        send_command(cmd);
    endtask

    // Random commands with every field filled from random bits, then biased per opcode.
    task automatic test_random_commands(input int count);
        t_cmd         cmd;
        logic [127:0] noise;
        int           pick;
        for (int n = 0; n < count; n++) begin
            // Change the idling pattern now and then, so that busy stretches occur too.
            if (n % 35 == 0) begin
                send_gaps_on  = 1'($urandom_range(0, 1));
                stall_gaps_on = 1'($urandom_range(0, 1));
            end
            noise = {$urandom(), $urandom(), $urandom(), $urandom()};
            cmd   = noise[$bits(t_cmd)-1:0];
            pick  = $urandom_range(0, 99);
            if (pick < 30) begin
                cmd.opcode = $urandom_range(0, 1) ? OP_FWD : OP_BACK;
                // Short moves keep the cursor away from the limits most of the time.
                if ($urandom_range(0, 1)) begin
                    cmd.distance = 20'(int'($urandom_range(0, 8191)) - 4096);
                end
            end else if (pick < 50) begin
                case ($urandom_range(0, 3))
                    0:       cmd.opcode = OP_ROTATE;
                    1:       cmd.opcode = OP_RIGHT;
                    2:       cmd.opcode = OP_LEFT;
                    default: cmd.opcode = OP_SETHEAD;
                endcase
            end else if (pick < 65) begin
                cmd.opcode = OP_ARC;
                // Mostly short arcs; the rest use the whole field and can hit the span cap.
                if ($urandom_range(0, 4) != 0) begin
                    cmd.arc_degrees = 8'(int'($urandom_range(0, 16)) - 8);
                end
            end else if (pick < 80) begin
                case ($urandom_range(0, 2))
                    0:       cmd.opcode = OP_SETX;
                    1:       cmd.opcode = OP_SETY;
                    default: cmd.opcode = OP_SETPOS;
                endcase
            end else if (pick < 94) begin
                cmd.opcode = $urandom_range(0, 1) ? OP_PENON : OP_PENOFF;
            end else begin
                cmd.opcode = 4'($urandom_range(FIRST_SPARE_OP, LAST_SPARE_OP));
            end
            send_command(cmd);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        test_pen_and_spare_codes();
        test_turns();
        test_moves_and_saturation();
        test_arcs();
        test_random_commands(256);
        cmd_valid <= 1'b0;
        while (pending_segments.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
